// ===== rtl/prt_pkg.sv =====
// Shared widths, codes and defaults of the pending resolution table.
package prt_pkg;

    localparam int MAC_BITS          = 48;
    localparam int HOP_BITS          = 8;
    localparam int HANDLE_FIELD_BITS = 16;
    localparam int SLOT_FIELD_BITS   = 4;
    localparam int STATUS_BITS       = 2;

    localparam int DEFAULT_TABLE_DEPTH = 16;
    localparam int DEFAULT_HANDLE_BITS = 16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FOUND    = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_MISSING  = 2'd3;

endpackage

// ===== rtl/prt_if.sv =====
// Request and response channel interfaces of the pending resolution table.
interface prt_req_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [prt_pkg::HANDLE_FIELD_BITS-1:0] packet_handle;
    logic [prt_pkg::MAC_BITS-1:0]  dst_mac;
    logic [prt_pkg::HOP_BITS-1:0]  route_hop;
    logic [prt_pkg::MAC_BITS-1:0]  lookup_mac;

    modport source (output valid, cmd, packet_handle, dst_mac, route_hop, lookup_mac,
                    input ready);
    modport sink   (input valid, cmd, packet_handle, dst_mac, route_hop, lookup_mac,
                    output ready);
endinterface

interface prt_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [prt_pkg::STATUS_BITS-1:0]       status;
    logic [prt_pkg::HANDLE_FIELD_BITS-1:0] found_handle;
    logic [prt_pkg::HOP_BITS-1:0]          found_route_hop;
    logic [prt_pkg::SLOT_FIELD_BITS-1:0]   slot_index;

    modport source (output valid, status, found_handle, found_route_hop, slot_index,
                    input ready);
    modport sink   (input valid, status, found_handle, found_route_hop, slot_index,
                    output ready);
endinterface

// ===== rtl/prt_store.sv =====
// Entry store: one write port, one read port with registered read data.
module prt_store #(
    parameter int DEPTH = prt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int WIDTH = prt_pkg::DEFAULT_HANDLE_BITS + prt_pkg::MAC_BITS
                          + prt_pkg::HOP_BITS,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/pending_resolution_table.sv =====
// Top level of the pending resolution table: scan control, occupied marks, result register.
//
// Table of packets parked while their next-hop MAC is being resolved.
// req channel: one beat is one command. Insert (cmd = 0) parks packet_handle,
// dst_mac and route_hop in the lowest free slot, or reports a full table and
// drops the beat. Remove (cmd = 1) frees the lowest occupied slot whose MAC
// equals lookup_mac and returns its handle and next hop, or reports not found.
// rsp channel: exactly one beat per request beat, in order.
// Timing: the table is walked one slot per cycle. An insert stops at the
// first free mark; a remove reads one entry of the store per cycle from
// its registered read port and compares each entry as it returns.
// The S_DONE state then moves the result into the output register. One
// command is worked at a time; req.ready is high only while no command is
// in flight, so a new beat is taken only after accept, scan and done.
// Stall: the output register holds a finished result while rsp.ready is low;
// a new command is still taken, and its result waits until the register frees.
// Reset clears all occupied marks at once (they are flip-flops); the entry
// store itself is not cleared, a free slot's contents are never used.
module pending_resolution_table #(
    parameter int TABLE_DEPTH = prt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int HANDLE_BITS = prt_pkg::DEFAULT_HANDLE_BITS
) (
    input  logic clk,
    input  logic rst_n,
    prt_req_if.sink   req,
    prt_rsp_if.source rsp
);

    localparam int MACW    = prt_pkg::MAC_BITS;
    localparam int HOPW    = prt_pkg::HOP_BITS;
    localparam int HFW     = prt_pkg::HANDLE_FIELD_BITS;
    localparam int SFW     = prt_pkg::SLOT_FIELD_BITS;
    localparam int STW     = prt_pkg::STATUS_BITS;
    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENTRY_W = HANDLE_BITS + MACW + HOPW;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INS  = 4'b0010,
        S_REM  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    // control
    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       scan_reg, scan_next;
    logic                   issue_reg, issue_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [TABLE_DEPTH-1:0] occ_reg, occ_next;
    logic                   out_valid_reg, out_valid_next;

    // payload
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [MACW-1:0]        mac_reg, mac_next;
    logic [HOPW-1:0]        hop_reg, hop_next;
    logic [STW-1:0]         res_status_reg, res_status_next;
    logic [HFW-1:0]         res_handle_reg, res_handle_next;
    logic [HOPW-1:0]        res_hop_reg, res_hop_next;
    logic [SFW-1:0]         res_slot_reg, res_slot_next;
    logic [STW-1:0]         out_status_reg, out_status_next;
    logic [HFW-1:0]         out_handle_reg, out_handle_next;
    logic [HOPW-1:0]        out_hop_reg, out_hop_next;
    logic [SFW-1:0]         out_slot_reg, out_slot_next;

    // store access
    logic               wr_en;
    logic               rd_en;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;

    logic [HANDLE_BITS+HFW-1:0] handle_in_wide;
    logic [HANDLE_BITS-1:0]     handle_in;
    logic [HANDLE_BITS-1:0]     rd_handle;
    logic [MACW-1:0]            rd_mac;
    logic [HOPW-1:0]            rd_hop;
    logic [HANDLE_BITS+HFW-1:0] rd_handle_wide;
    logic [IDX_W+SFW-1:0]       scan_wide;
    logic [IDX_W+SFW-1:0]       rd_idx_wide;
    logic                       accept;
    logic                       ins_free;
    logic                       rem_hit;

    // Stored handle keeps its low HANDLE_BITS; the result shows its low 16.
    assign handle_in_wide = {{HANDLE_BITS{1'b0}}, req.packet_handle};
    assign handle_in      = handle_in_wide[HANDLE_BITS-1:0];

    assign rd_handle      = rd_data[ENTRY_W-1 -: HANDLE_BITS];
    assign rd_mac         = rd_data[MACW+HOPW-1 -: MACW];
    assign rd_hop         = rd_data[HOPW-1:0];
    assign rd_handle_wide = {{HFW{1'b0}}, rd_handle};
    assign scan_wide      = {{SFW{1'b0}}, scan_reg};
    assign rd_idx_wide    = {{SFW{1'b0}}, rd_idx_reg};

    assign wr_data = {handle_reg, mac_reg, hop_reg};

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    // Marks do not change while a remove scan is running, so no bypass is needed.
    assign ins_free = !occ_reg[scan_reg];
    assign rem_hit  = rd_valid_reg && occ_reg[rd_idx_reg] && (rd_mac == mac_reg);

    prt_store #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (scan_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (scan_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        issue_next      = issue_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = rd_idx_reg;
        occ_next        = occ_reg;
        out_valid_next  = out_valid_reg;
        handle_next     = handle_reg;
        mac_next        = mac_reg;
        hop_next        = hop_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_hop_next    = res_hop_reg;
        res_slot_next   = res_slot_reg;
        out_status_next = out_status_reg;
        out_handle_next = out_handle_reg;
        out_hop_next    = out_hop_reg;
        out_slot_next   = out_slot_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;

        // output beat taken
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    handle_next = handle_in;
                    hop_next    = req.route_hop;
                    scan_next   = '0;
                    issue_next  = 1'b1;
                    if (req.cmd == prt_pkg::CMD_INSERT)
                    begin
                        mac_next   = req.dst_mac;
                        state_next = S_INS;
                    end
                    else
                    begin
                        mac_next   = req.lookup_mac;
                        state_next = S_REM;
                    end
                end
            end
            S_INS:
            begin
                res_handle_next = '0;
                res_hop_next    = '0;
                if (ins_free)
                begin
                    wr_en              = 1'b1;
                    occ_next[scan_reg] = 1'b1;
                    res_status_next    = prt_pkg::ST_INSERTED;
                    res_slot_next      = scan_wide[SFW-1:0];
                    state_next         = S_DONE;
                end
                else if (scan_reg == LAST_IDX)
                begin
                    res_status_next = prt_pkg::ST_FULL;
                    res_slot_next   = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            S_REM:
            begin
                // read issue, one slot a cycle
                if (issue_reg)
                begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_idx_next   = scan_reg;
                    if (scan_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_next = scan_reg + IDX_W'(1);
                    end
                end
                // compare on the returned entry
                if (rem_hit)
                begin
                    occ_next[rd_idx_reg] = 1'b0;
                    res_status_next      = prt_pkg::ST_FOUND;
                    res_handle_next      = rd_handle_wide[HFW-1:0];
                    res_hop_next         = rd_hop;
                    res_slot_next        = rd_idx_wide[SFW-1:0];
                    rd_valid_next        = 1'b0;
                    state_next           = S_DONE;
                end
                else if (rd_valid_reg && (rd_idx_reg == LAST_IDX))
                begin
                    res_status_next = prt_pkg::ST_MISSING;
                    res_handle_next = '0;
                    res_hop_next    = '0;
                    res_slot_next   = '0;
                    rd_valid_next   = 1'b0;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_handle_next = res_handle_reg;
                    out_hop_next    = res_hop_reg;
                    out_slot_next   = res_slot_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            issue_reg     <= 1'b0;
            rd_valid_reg  <= 1'b0;
            rd_idx_reg    <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            issue_reg     <= issue_next;
            rd_valid_reg  <= rd_valid_next;
            rd_idx_reg    <= rd_idx_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        handle_reg     <= handle_next;
        mac_reg        <= mac_next;
        hop_reg        <= hop_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_hop_reg    <= res_hop_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
        out_hop_reg    <= out_hop_next;
        out_slot_reg   <= out_slot_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.found_handle    = out_handle_reg;
    assign rsp.found_route_hop = out_hop_reg;
    assign rsp.slot_index      = out_slot_reg;

    // Marks change only on the cycle after an insert or remove scan step.
    a_occ_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_INS && state_reg != S_REM) |=> $stable(occ_reg))
        else $error("occupied marks changed outside a scan");

    // A successful insert adds exactly one mark.
    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS && ins_free)
        |=> ($countones(occ_reg) == $past($countones(occ_reg)) + 1))
        else $error("insert did not set exactly one mark");

    // Store read data is only consumed by a remove scan.
    a_rd_in_rem: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == S_REM))
        else $error("read data pending outside remove scan");

    // Full and not-found results carry zero payload.
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == prt_pkg::ST_FULL
                           || out_status_reg == prt_pkg::ST_MISSING))
        |-> (out_handle_reg == '0 && out_hop_reg == '0 && out_slot_reg == '0))
        else $error("nonzero payload on full or not-found result");

endmodule

// ===== bench/tb_pending_resolution_table.sv =====
// Testbench of the pending resolution table: directed and random traffic against a scoreboard.
module tb_pending_resolution_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = prt_pkg::DEFAULT_TABLE_DEPTH;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 14;
    localparam int POOL_SIZE   = 6;

    typedef logic [prt_pkg::HANDLE_FIELD_BITS-1:0] handle_t;
    typedef logic [prt_pkg::MAC_BITS-1:0]          mac_t;
    typedef logic [prt_pkg::HOP_BITS-1:0]          hop_t;

    // One request beat and one response beat, at the port widths.
    typedef struct packed {
        logic                                  cmd;
        logic [prt_pkg::HANDLE_FIELD_BITS-1:0] packet_handle;
        logic [prt_pkg::MAC_BITS-1:0]          dst_mac;
        logic [prt_pkg::HOP_BITS-1:0]          route_hop;
        logic [prt_pkg::MAC_BITS-1:0]          lookup_mac;
    } request_t;

    typedef struct packed {
        logic [prt_pkg::STATUS_BITS-1:0]       status;
        logic [prt_pkg::HANDLE_FIELD_BITS-1:0] found_handle;
        logic [prt_pkg::HOP_BITS-1:0]          found_route_hop;
        logic [prt_pkg::SLOT_FIELD_BITS-1:0]   slot_index;
    } outcome_t;

    logic clk;
    logic rst_n;

    prt_req_if req_ch ();
    prt_rsp_if rsp_ch ();

    pending_resolution_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the table: occupied marks plus the stored entries.
    bit      slot_busy  [DEPTH];
    handle_t slot_handle[DEPTH];
    mac_t    slot_mac   [DEPTH];
    hop_t    slot_hop   [DEPTH];

    outcome_t outcome_q[$];     // predicted responses, oldest first
    int       error_count = 0;
    int       cycle_count = 0;
    bit       no_idle     = 1'b0;   // set for the stretch with no bubbles or stalls

    mac_t mac_pool[POOL_SIZE];

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // All DUT inputs known from time zero.
    initial
    begin
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.cmd           = prt_pkg::CMD_INSERT;
        req_ch.packet_handle = '0;
        req_ch.dst_mac       = '0;
        req_ch.route_hop     = '0;
        req_ch.lookup_mac    = '0;
        rsp_ch.ready         = 1'b0;
        foreach (slot_busy[s])
            slot_busy[s] = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_pending_resolution_table: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Table predictor: lowest free slot on insert, lowest matching
    // occupied slot on remove. Only occupied slots are ever compared,
    // so entries never written are never read.
    // ------------------------------------------------------------------
    function automatic outcome_t table_outcome(input request_t rq);
        outcome_t o;
        bit       done;
        o    = '0;
        done = 1'b0;
        if (rq.cmd == prt_pkg::CMD_INSERT)
        begin
            o.status = prt_pkg::ST_FULL;
            for (int s = 0; s < DEPTH && !done; s++)
            begin
                if (!slot_busy[s])
                begin
                    slot_busy[s]   = 1'b1;
                    slot_handle[s] = rq.packet_handle;
                    slot_mac[s]    = rq.dst_mac;
                    slot_hop[s]    = rq.route_hop;
                    o.status       = prt_pkg::ST_INSERTED;
                    o.slot_index   = s[prt_pkg::SLOT_FIELD_BITS-1:0];
                    done           = 1'b1;
                end
            end
        end
        else
        begin
            o.status = prt_pkg::ST_MISSING;
            for (int s = 0; s < DEPTH && !done; s++)
            begin
                if (slot_busy[s] && slot_mac[s] == rq.lookup_mac)
                begin
                    slot_busy[s]      = 1'b0;
                    o.status          = prt_pkg::ST_FOUND;
                    o.found_handle    = slot_handle[s];
                    o.found_route_hop = slot_hop[s];
                    o.slot_index      = s[prt_pkg::SLOT_FIELD_BITS-1:0];
                    done              = 1'b1;
                end
            end
        end
        return o;
    endfunction

    function automatic mac_t rand_mac();
        return mac_t'({$urandom, $urandom});
    endfunction

    // ------------------------------------------------------------------
    // Request driver. Entered at a falling edge; leaves at the falling
    // edge after the beat is taken, so valid gets at most one NBA per step.
    // ------------------------------------------------------------------
    task automatic send_beat(input request_t rq);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= rq.cmd;
        req_ch.packet_handle <= rq.packet_handle;
        req_ch.dst_mac       <= rq.dst_mac;
        req_ch.route_hop     <= rq.route_hop;
        req_ch.lookup_mac    <= rq.lookup_mac;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // beat accepted at this edge: predict in acceptance order
        outcome_q.push_back(table_outcome(rq));
        @(negedge clk);
    endtask

    // Unused fields of each command carry random junk.
    task automatic send_insert(input handle_t handle, input mac_t mac, input hop_t hop);
        request_t rq;
        rq.cmd           = prt_pkg::CMD_INSERT;
        rq.packet_handle = handle;
        rq.dst_mac       = mac;
        rq.route_hop     = hop;
        rq.lookup_mac    = rand_mac();
        send_beat(rq);
    endtask

    task automatic send_remove(input mac_t mac);
        request_t rq;
        rq.cmd           = prt_pkg::CMD_REMOVE;
        rq.packet_handle = handle_t'($urandom);
        rq.dst_mac       = rand_mac();
        rq.route_hop     = hop_t'($urandom);
        rq.lookup_mac    = mac;
        send_beat(rq);
    endtask

    // ------------------------------------------------------------------
    // Response side: random stalls, in-order compare against predictions
    // ------------------------------------------------------------------
    always @(negedge clk)
        rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (outcome_q.size() == 0)
            begin
                $error("response beat with no request pending: status 0x%0h",
                       rsp_ch.status);
                error_count++;
            end
            else
            begin
                want = outcome_q.pop_front();
                check_field("status", 32'(want.status), 32'(rsp_ch.status));
                check_field("found_handle", 32'(want.found_handle),
                            32'(rsp_ch.found_handle));
                check_field("found_route_hop", 32'(want.found_route_hop),
                            32'(rsp_ch.found_route_hop));
                check_field("slot_index", 32'(want.slot_index), 32'(rsp_ch.slot_index));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty-table miss, fill to capacity with extreme field values,
    // overflow drop, duplicate MACs, refill of the lowest hole.
    task automatic test_directed();
        mac_t dup_mac;
        dup_mac = 48'h0123_4567_89AB;
        send_remove(48'h0);                                 // nothing stored yet
        send_insert(16'h0000, 48'h0, 8'h00);                // slot 0: all zero
        send_insert(16'hFFFF, 48'hFFFF_FFFF_FFFF, 8'hFF);   // slot 1: all ones
        for (int s = 2; s < DEPTH; s++)
        begin
            if (s == 5 || s == 9)
                send_insert(handle_t'($urandom), dup_mac, hop_t'($urandom)); // same MAC twice
            else
                send_insert(handle_t'($urandom), rand_mac(), hop_t'($urandom));
        end
        send_insert(16'hA5A5, 48'h5A5A_5A5A_5A5A, 8'hC3);   // table full: dropped
        send_remove(dup_mac);                               // lower duplicate first
        send_remove(dup_mac);                               // then the upper one
        send_remove(dup_mac);                               // gone: miss
        send_insert(16'h1234, 48'hDEAD_BEEF_0001, 8'h42);   // fills lowest hole
        send_remove(48'hFFFF_FFFF_FFFF);
        send_remove(48'h0);
        send_remove(48'h5A5A_5A5A_5A5A);                    // dropped entry never stored
    endtask

    // Phases that lean toward filling or draining, so the table swings
    // between empty and full. MACs mostly come from a small pool so that
    // removes hit and duplicates pile up; some removes target a MAC that
    // is known to be stored, some are random noise.
    task automatic test_random_traffic(input int n_items);
        int   sent;
        int   phase_len;
        int   ins_pct;
        int   busy_cnt;
        int   pick;
        int   roll;
        mac_t mac;
        sent = 0;
        foreach (mac_pool[i])
            mac_pool[i] = rand_mac();
        while (sent < n_items)
        begin
            phase_len = $urandom_range(20, 80);
            ins_pct   = ($urandom_range(1) == 0) ? 75 : 30;
            mac_pool[$urandom_range(POOL_SIZE-1)] = rand_mac();
            for (int k = 0; k < phase_len && sent < n_items; k++)
            begin
                if ($urandom_range(99) < ins_pct)
                begin
                    if ($urandom_range(99) < 85)
                        mac = mac_pool[$urandom_range(POOL_SIZE-1)];
                    else
                        mac = rand_mac();
                    send_insert(handle_t'($urandom), mac, hop_t'($urandom));
                end
                else
                begin
                    roll     = $urandom_range(99);
                    busy_cnt = 0;
                    foreach (slot_busy[s])
                        busy_cnt += slot_busy[s];
                    if (roll < 35 && busy_cnt > 0)
                    begin
                        // pick the MAC of a random occupied slot
                        pick = $urandom_range(busy_cnt - 1);
                        mac  = '0;
                        foreach (slot_busy[s])
                        begin
                            if (slot_busy[s])
                            begin
                                if (pick == 0)
                                    mac = slot_mac[s];
                                pick--;
                            end
                        end
                    end
                    else if (roll < 85)
                        mac = mac_pool[$urandom_range(POOL_SIZE-1)];
                    else
                        mac = rand_mac();
                    send_remove(mac);
                end
                sent++;
            end
        end
    endtask

    // Same traffic with both sides always ready: back-to-back beats.
    task automatic test_back_to_back(input int n_items);
        no_idle = 1'b1;
        test_random_traffic(n_items);
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random_traffic(1500);
        test_back_to_back(250);
        test_random_traffic(175);

        req_ch.valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        // drain margin once every predicted response has been seen
        repeat (2 * DEPTH + 8) @(posedge clk);

        if (error_count == 0)
            $display("tb_pending_resolution_table: done, clean");
        else
            $display("tb_pending_resolution_table: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/prt_pkg.sv
rtl/prt_if.sv
rtl/prt_store.sv
rtl/pending_resolution_table.sv
bench/tb_pending_resolution_table.sv
